@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the framer RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/core/wbf_pkg.sv @@
// Shared types and constants of the word block framer.
// No dependencies.
package wbf_pkg;

    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int LEFT_W         = 7;
    localparam int MAX_BODY_WORDS = 61;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED = 2'd1;

    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;

    // What the front end decided a word is.
    typedef enum logic [1:0] {
        KIND_ERR  = 2'd0,
        KIND_LEN  = 2'd1,
        KIND_BODY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        kind_t             kind;
        logic              close;   // last word of the block: CRC follows
    } entry_t;

endpackage

@@ rtl/core/wbf_front.sv @@
// Front end of the framer: takes words, tracks block position, classifies.
// Depends on wbf_pkg.
module wbf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       word_valid,
    output logic                       word_ready,
    input  logic [wbf_pkg::WORD_W-1:0] word,
    input  logic                       queue_full,
    output logic                       push,
    output wbf_pkg::entry_t            entry
);
    import wbf_pkg::*;

    logic              in_block_reg;
    logic              in_block_next;
    logic [LEFT_W-1:0] words_left_reg;
    logic [LEFT_W-1:0] words_left_next;

    assign word_ready = !queue_full;
    assign push       = word_valid && word_ready;

    always_comb
    begin
        in_block_next   = in_block_reg;
        words_left_next = words_left_reg;
        entry.word      = word;
        entry.kind      = KIND_ERR;
        entry.close     = 1'b0;
        if (!in_block_reg)
        begin
            if (word > WORD_W'(MAX_BODY_WORDS))
            begin
                entry.kind = KIND_ERR;
            end
            else
            begin
                entry.kind      = KIND_LEN;
                entry.close     = (word == '0);
                in_block_next   = (word != '0);
                words_left_next = word[LEFT_W-1:0];
            end
        end
        else
        begin
            entry.kind      = KIND_BODY;
            entry.close     = (words_left_reg == LEFT_W'(1));
            words_left_next = words_left_reg - LEFT_W'(1);
            if (words_left_reg == LEFT_W'(1))
            begin
                in_block_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg   <= 1'b0;
            words_left_reg <= '0;
        end
        else if (push)
        begin
            in_block_reg   <= in_block_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule

@@ rtl/core/wbf_queue.sv @@
// Short queue of classified words between front and back end.
// Depends on wbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wbf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wbf_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output wbf_pkg::entry_t head,
    output logic            empty
);
    import wbf_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    `ASSERT_IMP(a_no_overflow, push, !full)
    `ASSERT_IMP(a_no_underflow, pop, !empty)
    `ASSERT_IMP(a_count_range, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

@@ rtl/core/wbf_back.sv @@
// Back end of the framer: byte sequencer, CRC update, output register.
// Depends on wbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wbf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wbf_pkg::entry_t            head,
    input  logic                       empty,
    output logic                       pop,
    input  logic [15:0]                crc_poly,
    input  logic [15:0]                crc_seed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wbf_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       out_err
);
    import wbf_pkg::*;

    // Steps after the first byte of an entry, which goes out on the pop.
    localparam logic [2:0] STEP_LENB = 3'd0;
    localparam logic [2:0] STEP_HI   = 3'd1;
    localparam logic [2:0] STEP_LO   = 3'd2;
    localparam logic [2:0] STEP_CRCH = 3'd3;
    localparam logic [2:0] STEP_CRCL = 3'd4;

    // Eight MSB-first CRC steps over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[15] ^ d[7])
            begin
                c = {c[14:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

    logic              active_reg, active_next;
    logic [2:0]        step_reg, step_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              close_reg, close_next;
    logic [15:0]       crc_reg, crc_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, byte_sel;
    logic              out_last_reg, last_sel;
    logic              out_err_reg, err_sel;
    logic              out_free;
    logic              load;
    logic [BYTE_W-1:0] len_byte;

    assign out_free = !out_valid_reg || out_ready;
    // 2*(L+3); L is at most the maximum body length here, so it fits a byte.
    assign len_byte = BYTE_W'({word_reg[BYTE_W-2:0], 1'b0} + BYTE_W'(6));

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        word_next   = word_reg;
        close_next  = close_reg;
        crc_next    = crc_reg;
        byte_sel    = '0;
        last_sel    = 1'b0;
        err_sel     = 1'b0;
        load        = 1'b0;
        pop         = 1'b0;
        if (out_free)
        begin
            if (active_reg)
            begin
                load = 1'b1;
                unique case (step_reg)
                    STEP_LENB:
                    begin
                        byte_sel  = len_byte;
                        step_next = STEP_HI;
                    end
                    STEP_HI:
                    begin
                        // only reached from a length word: CRC starts from the seed
                        byte_sel  = word_reg[15:8];
                        crc_next  = crc_byte(crc_seed, word_reg[15:8], crc_poly);
                        step_next = STEP_LO;
                    end
                    STEP_LO:
                    begin
                        byte_sel = word_reg[7:0];
                        crc_next = crc_byte(crc_reg, word_reg[7:0], crc_poly);
                        if (close_reg)
                        begin
                            step_next = STEP_CRCH;
                        end
                        else
                        begin
                            active_next = 1'b0;
                        end
                    end
                    STEP_CRCH:
                    begin
                        byte_sel  = crc_reg[15:8];
                        step_next = STEP_CRCL;
                    end
                    STEP_CRCL:
                    begin
                        byte_sel    = crc_reg[7:0];
                        last_sel    = 1'b1;
                        active_next = 1'b0;
                    end
                    default:
                    begin
                        load        = 1'b0;
                        active_next = 1'b0;
                    end
                endcase
            end
            else if (!empty)
            begin
                pop        = 1'b1;
                load       = 1'b1;
                word_next  = head.word;
                close_next = head.close;
                unique case (head.kind)
                    KIND_ERR:
                    begin
                        err_sel = 1'b1;
                    end
                    KIND_LEN:
                    begin
                        active_next = 1'b1;
                        step_next   = STEP_LENB;
                    end
                    KIND_BODY:
                    begin
                        byte_sel    = head.word[15:8];
                        crc_next    = crc_byte(crc_reg, head.word[15:8], crc_poly);
                        active_next = 1'b1;
                        step_next   = STEP_LO;
                    end
                    default:
                    begin
                        load = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= STEP_LENB;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            crc_reg    <= crc_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        close_reg <= close_next;
        if (load)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= last_sel;
            out_err_reg  <= err_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

    `ASSERT_IMP(a_last_not_err, out_valid && out_last, !out_err)
    `ASSERT_IMP(a_pop_when_idle, pop, !active_reg)
    `ASSERT_NXT(a_crcl_closes, active_reg && out_free && (step_reg == STEP_CRCL),
                out_valid && out_last && !active_reg)

endmodule

@@ rtl/core/word_block_framer_crc16_unit.sv @@
// Word block framer with CRC-16: top level, configuration registers.
// Depends on wbf_pkg, wbf_front, wbf_queue, wbf_back.
//
// Input stream s_axis carries 16-bit block words. The first word of a block
// is its length L (0 to 61); L body words follow. Output stream m_axis carries
// the byte frame: 0x00, 2*(L+3), each word high byte then low byte, then the
// CRC-16 (MSB-first) over all L+1 words, high byte then low byte; tlast marks
// the low CRC byte. A length word above 61 gives one byte with tuser set and
// opens no block.
// The cfg channel writes crc_poly (index 0) and crc_seed (index 1); other
// indexes are ignored. cfg_ready is always high; write only while idle.
// A word taken from s_axis is written into a queue slot; its first byte then
// goes into the output register, with the queue empty and byte sequencer idle.
// Throughput: one byte per cycle while m_axis_tready is high and words wait;
// a body word gives two bytes, a length word four (six for an empty block, one
// for a rejected one). The byte sequencer in the back end sets this rate.
// A four-entry queue separates the input side from the byte sequencer, and
// the output register holds a byte while m_axis_tready is low; the input
// keeps accepting until the queue fills. Reset empties the queue, drops any
// open block and restores the register defaults (0x1021, 0xFFFF).
module word_block_framer_crc16_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // [15:0] word_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] byte_out
    output logic                            m_axis_tlast,   // frame_end
    output logic [0:0]                      m_axis_tuser,   // [0] length_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import wbf_pkg::*;

    logic [15:0] crc_poly_reg;
    logic [15:0] crc_seed_reg;
    logic        push;
    entry_t      push_entry;
    logic        queue_full;
    logic        pop;
    entry_t      head;
    logic        queue_empty;
    logic        out_err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg <= CRC_POLY_RESET;
            crc_seed_reg <= CRC_SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_CRC_POLY)
            begin
                crc_poly_reg <= cfg_data;
            end
            else if (cfg_index == CFG_CRC_SEED)
            begin
                crc_seed_reg <= cfg_data;
            end
        end
    end

    wbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (s_axis_tvalid),
        .word_ready (s_axis_tready),
        .word       (s_axis_tdata),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    wbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty)
    );

    wbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .crc_poly  (crc_poly_reg),
        .crc_seed  (crc_seed_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_err   (out_err)
    );

    assign m_axis_tuser = out_err;

endmodule
